/* design/txrb_pkg.sv */
package txrb_pkg;

  // Default store depth
  localparam int BUF_DEPTH_DEF = 256;

  // Stream widths: fields packed from bit 0, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Item kinds carried on in_tuser
  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_READ     = 2'd2
  } action_t;

  // Result of one item, passed from the pointer logic to the output register
  typedef struct packed {
    logic       accepted;
    logic       segment_valid;
    logic [7:0] segment_start;
    logic [8:0] segment_length;
    logic       is_idle;
    logic [8:0] fill_count;
    logic       rd_en;
  } res_t;

endpackage

/* design/txrb_store.sv */
module txrb_store #(
  parameter int BUF_DEPTH = txrb_pkg::BUF_DEPTH_DEF,
  parameter int IDX_W     = $clog2(BUF_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [7:0]       wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [7:0]       rdata
);

  logic [7:0] mem [BUF_DEPTH];
  logic [7:0] rdata_r;

  // Write queued byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data, hold while the result waits
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/txrb_ctrl.sv */
module txrb_ctrl #(
  parameter int BUF_DEPTH = txrb_pkg::BUF_DEPTH_DEF,
  parameter int IDX_W     = $clog2(BUF_DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [1:0]       action,
  input  logic             eow,
  input  logic [7:0]       rd_idx,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [IDX_W-1:0] mem_raddr,
  output txrb_pkg::res_t   res
);

  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(BUF_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(BUF_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_DEPTH - 1);

  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] fl_idx_r, fl_idx_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0] infl_r, infl_nxt;
  logic             idle_r, idle_nxt;
  logic             issue_req;
  logic [CNT_W-1:0] run_len;
  logic [SUM_W-1:0] fl_sum;

  // Length of the contiguous queued run starting at the flush index
  function automatic logic [CNT_W-1:0] run_from(input logic [IDX_W-1:0] fl,
                                                input logic [IDX_W-1:0] wr,
                                                input logic [CNT_W-1:0] pend);
    logic [CNT_W-1:0] r;
    if (fl < wr) begin
      r = CNT_W'(wr) - CNT_W'(fl);
    end else if (fl > wr || pend != '0) begin
      r = DEPTH_C - CNT_W'(fl);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // Next pointer state and result fields for the item at the input
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    fl_idx_nxt = fl_idx_r;
    pend_nxt   = pend_r;
    infl_nxt   = infl_r;
    idle_nxt   = idle_r;
    issue_req  = 1'b0;
    mem_we     = 1'b0;
    fl_sum     = SUM_W'(fl_idx_r) + SUM_W'(infl_r);
    res        = '0;

    unique case (txrb_pkg::action_t'(action))
      txrb_pkg::ACT_WRITE: begin
        if (pend_r < DEPTH_C) begin
          wr_idx_nxt   = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
          pend_nxt     = pend_r + 1'b1;
          mem_we       = 1'b1;
          res.accepted = 1'b1;
        end
        issue_req = eow && idle_r;
      end
      txrb_pkg::ACT_COMPLETE: begin
        if (idle_r) begin
          // Drop everything queued
          wr_idx_nxt = '0;
          fl_idx_nxt = '0;
          pend_nxt   = '0;
          infl_nxt   = '0;
        end else begin
          // Retire the segment in flight
          if (fl_sum >= DEPTH_S) begin
            fl_sum = fl_sum - DEPTH_S;
          end
          fl_idx_nxt = fl_sum[IDX_W-1:0];
          pend_nxt   = (pend_r > infl_r) ? pend_r - infl_r : '0;
          if (pend_nxt != '0) begin
            issue_req = 1'b1;
          end else begin
            idle_nxt = 1'b1;
            infl_nxt = '0;
          end
        end
      end
      txrb_pkg::ACT_READ: begin
        res.rd_en = (32'(rd_idx) < 32'(BUF_DEPTH));
      end
      default: begin
      end
    endcase

    // Issue the next segment from the updated pointers
    run_len = run_from(fl_idx_nxt, wr_idx_nxt, pend_nxt);
    if (issue_req) begin
      infl_nxt = run_len;
      if (run_len != '0) begin
        idle_nxt           = 1'b0;
        res.segment_valid  = 1'b1;
        res.segment_start  = 8'(fl_idx_nxt);
        res.segment_length = 9'(run_len);
      end
    end

    res.is_idle    = idle_nxt;
    res.fill_count = 9'(pend_nxt);
  end

  assign mem_waddr = wr_idx_r;
  assign mem_raddr = IDX_W'(rd_idx);

  // Advance pointer state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      fl_idx_r <= '0;
      pend_r   <= '0;
      infl_r   <= '0;
      idle_r   <= 1'b1;
    end else if (accept) begin
      wr_idx_r <= wr_idx_nxt;
      fl_idx_r <= fl_idx_nxt;
      pend_r   <= pend_nxt;
      infl_r   <= infl_nxt;
      idle_r   <= idle_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= DEPTH_C)
    else $error("queued count exceeds store depth");

  a_idle_no_flight: assert property (@(posedge clk) disable iff (!rst_n)
    idle_r |-> infl_r == '0)
    else $error("segment length left over while idle");

  a_busy_segment: assert property (@(posedge clk) disable iff (!rst_n)
    !idle_r |-> (infl_r != '0 && infl_r <= pend_r))
    else $error("in-flight segment inconsistent with queued count");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(idle_r) |-> pend_r == '0)
    else $error("went idle with bytes still queued");
`endif

endmodule

/* design/tx_ring_buffer_dma_segmenter.sv */
// Transmit ring buffer with DMA segment issue. Each transaction on the in_
// stream is a write of one byte, a transfer completion or a read of a stored
// byte, and yields exactly one result transaction on the out_ stream. A full
// store rejects a written byte (accepted = 0). At the end of a write burst an
// idle block issues a segment (start index and a length that stops at the
// store end); each completion retires the segment in flight and issues the
// next one or goes idle; a completion while idle drops everything queued.
// One item is taken per clock cycle while the output register is free or
// draining; its result enters the output register on acceptance. The rate
// is set by the combinational pointer update and the one write plus one
// registered read port of the byte store. No clearing pass follows reset:
// the store is readable only where written; the user, not the block, sees to it.
module tx_ring_buffer_dma_segmenter #(
  parameter int BUF_DEPTH = txrb_pkg::BUF_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] data_byte, [15:8] read_index
  input  logic [txrb_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [1:0]                       in_tuser,
  // end_of_write
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] accepted, [1] segment_valid, [9:2] segment_start,
  // [18:10] segment_length, [26:19] read_data, [27] is_idle,
  // [36:28] fill_count, [39:37] zero
  output logic [txrb_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(BUF_DEPTH);

  logic             accept;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;
  logic [7:0]       rd_data;
  txrb_pkg::res_t   res;
  txrb_pkg::res_t   res_r;
  logic             out_valid_r;

  // Take a transaction whenever the output register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  txrb_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_tuser),
    .eow       (in_tlast),
    .rd_idx    (in_tdata[15:8]),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .res       (res)
  );

  txrb_store #(
    .BUF_DEPTH (BUF_DEPTH),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk   (clk),
    .we    (accept && mem_we),
    .waddr (mem_waddr),
    .wdata (in_tdata[7:0]),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  // Zero the read byte on items other than an in-range read
  assign rd_data = res_r.rd_en ? mem_rdata : 8'h00;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.fill_count, res_r.is_idle, rd_data,
                       res_r.segment_length, res_r.segment_start,
                       res_r.segment_valid, res_r.accepted};

endmodule
